### hdl/dptsd_pkg.sv
// shared types, constants and codes of the dual peak/trough settle detector
package dptsd_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int STEP_W     = 24;
    localparam int TOL_W      = 24;
    localparam int LIMIT_W    = 31;
    localparam int FLAG_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [STEP_W-1:0]          t_step;
    typedef logic [TOL_W-1:0]           t_tol;
    typedef logic [LIMIT_W-1:0]         t_limit;
    typedef logic [FLAG_W-1:0]          t_flags;
    typedef logic [1:0]                 t_trend;

    // trend codes
    localparam t_trend TREND_NONE = 2'd0;
    localparam t_trend TREND_RISE = 2'd1;
    localparam t_trend TREND_FALL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOWUP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 2'd2;

    // register reset values
    localparam t_tol   TOL_RST       = 24'd1678;
    localparam t_limit BLOWUP_RST    = 31'd167772160;
    localparam t_step  MAX_STEPS_RST = 24'd100000;

    // settle flag bits
    localparam t_flags FLAG_PEAK_A   = 4'h1;
    localparam t_flags FLAG_TROUGH_A = 4'h2;
    localparam t_flags FLAG_PEAK_B   = 4'h4;
    localparam t_flags FLAG_TROUGH_B = 4'h8;
    localparam t_flags FLAGS_ALL     = 4'hf;

    // what one channel tracker reports for the current step
    typedef struct packed {
        logic rec;    // an extreme was recorded
        logic close;  // the old extreme was within tolerance
        logic peak;   // the record was a peak (else a trough)
    } t_track_ev;

endpackage

### hdl/dptsd_in_if.sv
// input channel: start request and a sample pair
interface dptsd_in_if;
    import dptsd_pkg::*;

    logic    valid;
    logic    ready;
    logic    start_req;
    t_sample sample_a;
    t_sample sample_b;

    modport source (output valid, output start_req, output sample_a, output sample_b,
                    input ready);
    modport sink   (input valid, input start_req, input sample_a, input sample_b,
                    output ready);
endinterface

### hdl/dptsd_out_if.sv
// result channel: recorded extremes, step index, flags and done
interface dptsd_out_if;
    import dptsd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample max_a;
    t_sample min_a;
    t_sample max_b;
    t_sample min_b;
    t_step   step_index;
    t_flags  settle_flags;
    logic    done_res;

    modport source (output valid, output max_a, output min_a, output max_b, output min_b,
                    output step_index, output settle_flags, output done_res,
                    input ready);
    modport sink   (input valid, input max_a, input min_a, input max_b, input min_b,
                    input step_index, input settle_flags, input done_res,
                    output ready);
endinterface

### hdl/dptsd_track.sv
// one channel's trend tracker: turn detection and tolerance check
module dptsd_track
    import dptsd_pkg::*;
(
    input  t_sample   i_cur,
    input  t_sample   i_prev,
    input  t_sample   i_peak,
    input  t_sample   i_trough,
    input  t_trend    i_trend,
    input  t_tol      i_tol,
    output t_sample   o_peak,
    output t_sample   o_trough,
    output t_trend    o_trend,
    output t_track_ev o_ev
);
    logic                       falling;
    t_sample                    old_ext;
    logic signed [SAMPLE_W:0]   diff;
    logic        [SAMPLE_W:0]   mag;

    assign falling = (i_cur < i_prev);

    // old extreme that a turn would replace
    assign old_ext = falling ? i_peak : i_trough;
    assign diff    = {old_ext[SAMPLE_W-1], old_ext} - {i_prev[SAMPLE_W-1], i_prev};
    assign mag     = diff[SAMPLE_W] ? (SAMPLE_W+1)'(0) - diff : diff;

    always_comb begin
        o_peak      = i_peak;
        o_trough    = i_trough;
        o_trend     = i_trend;
        o_ev.rec    = 1'b0;
        o_ev.peak   = falling;
        o_ev.close  = (mag < {{(SAMPLE_W+1-TOL_W){1'b0}}, i_tol});
        if (falling) begin
            if (i_trend == TREND_RISE) begin
                o_peak   = i_prev;
                o_trend  = TREND_NONE;
                o_ev.rec = 1'b1;
            end else begin
                o_trend = TREND_FALL;
            end
        end else begin
            // equal samples count as rising
            if (i_trend == TREND_FALL) begin
                o_trough = i_prev;
                o_trend  = TREND_NONE;
                o_ev.rec = 1'b1;
            end else begin
                o_trend = TREND_RISE;
            end
        end
    end
endmodule

### hdl/dual_peak_trough_settle_detector.sv
// top level of the dual peak/trough settle detector
//
// Takes one sample pair per cycle and returns one result per transfer in the cycle
// after it is taken. All tracking is done in a single combinational pass from the
// held channel state to the state and result registers; the result register is
// kept apart from the state so that a new transfer is taken in the same cycle as
// the previous result leaves, while a result that waits for the receiver stalls
// the input. A start transfer loads both samples as previous value, peak
// and trough and clears trends, flags and step count. After done, data transfers
// leave the state alone and repeat the held result. Configuration registers are
// written through i_cfg_we / i_cfg_idx / i_cfg_data; index 3 is ignored.
module dual_peak_trough_settle_detector
    import dptsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dptsd_in_if.sink              i_item,
    dptsd_out_if.source           o_res
);
    // configuration
    t_tol   r_tol;
    t_limit r_blowup;
    t_step  r_max_steps;

    // channel state
    t_sample r_prev_a, r_prev_b, r_peak_a, r_trough_a, r_peak_b, r_trough_b;
    t_trend  r_trend_a, r_trend_b;
    t_flags  r_flags;
    t_step   r_count;
    logic    r_done;

    t_sample n_prev_a, n_prev_b, n_peak_a, n_trough_a, n_peak_b, n_trough_b;
    t_trend  n_trend_a, n_trend_b;
    t_flags  n_flags;
    t_step   n_count;
    logic    n_done;

    // result register
    logic    r_out_valid;
    t_sample r_max_a, r_min_a, r_max_b, r_min_b;
    t_step   r_step_index;
    t_flags  r_out_flags;
    logic    r_out_done;

    t_sample   trk_peak_a, trk_trough_a, trk_peak_b, trk_trough_b;
    t_trend    trk_trend_a, trk_trend_b;
    t_track_ev ev_a, ev_b;
    t_flags    flags_a, flags_b;
    logic      accept;
    logic      blown_up;

    assign i_item.ready = !r_out_valid || o_res.ready;
    assign accept       = i_item.valid && i_item.ready;

    dptsd_track u_track_a (
        .i_cur    (i_item.sample_a),
        .i_prev   (r_prev_a),
        .i_peak   (r_peak_a),
        .i_trough (r_trough_a),
        .i_trend  (r_trend_a),
        .i_tol    (r_tol),
        .o_peak   (trk_peak_a),
        .o_trough (trk_trough_a),
        .o_trend  (trk_trend_a),
        .o_ev     (ev_a)
    );

    dptsd_track u_track_b (
        .i_cur    (i_item.sample_b),
        .i_prev   (r_prev_b),
        .i_peak   (r_peak_b),
        .i_trough (r_trough_b),
        .i_trend  (r_trend_b),
        .i_tol    (r_tol),
        .o_peak   (trk_peak_b),
        .o_trough (trk_trough_b),
        .o_trend  (trk_trend_b),
        .o_ev     (ev_b)
    );

    // channel a first, so a mismatch on b also clears what a set
    always_comb begin
        flags_a = r_flags;
        if (ev_a.rec) begin
            flags_a = !ev_a.close ? '0 :
                      (r_flags | (ev_a.peak ? FLAG_PEAK_A : FLAG_TROUGH_A));
        end
        flags_b = flags_a;
        if (ev_b.rec) begin
            flags_b = !ev_b.close ? '0 :
                      (flags_a | (ev_b.peak ? FLAG_PEAK_B : FLAG_TROUGH_B));
        end
    end

    // signed peak against unsigned limit
    assign blown_up = ($signed({trk_peak_a[SAMPLE_W-1], trk_peak_a}) >
                       $signed({{(SAMPLE_W+1-LIMIT_W){1'b0}}, r_blowup}));

    always_comb begin
        n_prev_a   = r_prev_a;
        n_prev_b   = r_prev_b;
        n_peak_a   = r_peak_a;
        n_trough_a = r_trough_a;
        n_peak_b   = r_peak_b;
        n_trough_b = r_trough_b;
        n_trend_a  = r_trend_a;
        n_trend_b  = r_trend_b;
        n_flags    = r_flags;
        n_count    = r_count;
        n_done     = r_done;
        if (i_item.start_req) begin
            n_prev_a   = i_item.sample_a;
            n_peak_a   = i_item.sample_a;
            n_trough_a = i_item.sample_a;
            n_prev_b   = i_item.sample_b;
            n_peak_b   = i_item.sample_b;
            n_trough_b = i_item.sample_b;
            n_trend_a  = TREND_NONE;
            n_trend_b  = TREND_NONE;
            n_flags    = '0;
            n_count    = '0;
            n_done     = (r_max_steps == '0);
        end else if (!r_done) begin
            if (r_count >= r_max_steps) begin
                // limit lowered to or below the count
                n_done = 1'b1;
            end else begin
                n_prev_a   = i_item.sample_a;
                n_prev_b   = i_item.sample_b;
                n_peak_a   = trk_peak_a;
                n_trough_a = trk_trough_a;
                n_peak_b   = trk_peak_b;
                n_trough_b = trk_trough_b;
                n_trend_a  = trk_trend_a;
                n_trend_b  = trk_trend_b;
                n_flags    = flags_b;
                n_count    = (&r_count) ? r_count : r_count + 1'b1;
                n_done     = (flags_b == FLAGS_ALL) || blown_up || (n_count >= r_max_steps);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RST;
            r_blowup    <= BLOWUP_RST;
            r_max_steps <= MAX_STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOLERANCE: r_tol       <= i_cfg_data[TOL_W-1:0];
                REG_BLOWUP:    r_blowup    <= i_cfg_data[LIMIT_W-1:0];
                REG_MAX_STEPS: r_max_steps <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a    <= '0;
            r_prev_b    <= '0;
            r_peak_a    <= '0;
            r_trough_a  <= '0;
            r_peak_b    <= '0;
            r_trough_b  <= '0;
            r_trend_a   <= TREND_NONE;
            r_trend_b   <= TREND_NONE;
            r_flags     <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
        end else if (accept) begin
            r_prev_a    <= n_prev_a;
            r_prev_b    <= n_prev_b;
            r_peak_a    <= n_peak_a;
            r_trough_a  <= n_trough_a;
            r_peak_b    <= n_peak_b;
            r_trough_b  <= n_trough_b;
            r_trend_a   <= n_trend_a;
            r_trend_b   <= n_trend_b;
            r_flags     <= n_flags;
            r_count     <= n_count;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_max_a      <= n_peak_a;
            r_min_a      <= n_trough_a;
            r_max_b      <= n_peak_b;
            r_min_b      <= n_trough_b;
            r_step_index <= (n_count == '0) ? '0 : n_count - 1'b1;
            r_out_flags  <= n_flags;
            r_out_done   <= n_done;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.max_a        = r_max_a;
    assign o_res.min_a        = r_min_a;
    assign o_res.max_b        = r_max_b;
    assign o_res.min_b        = r_min_b;
    assign o_res.step_index   = r_step_index;
    assign o_res.settle_flags = r_out_flags;
    assign o_res.done_res     = r_out_done;
endmodule
